// ----- hw/rtl/pipc_pkg.sv -----
// shared types, constants and helpers for the point-in-polygon crossing block
package pipc_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int COORD_WIDTH  = 32;
  localparam int ADDR_WIDTH   = $clog2(MAX_VERTICES);
  localparam int CNT_WIDTH    = $clog2(MAX_VERTICES + 1);
  localparam int ENTRY_WIDTH  = 2 * COORD_WIDTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [CNT_WIDTH-1:0]          cnt_t;
  typedef logic [ADDR_WIDTH-1:0]         addr_t;
  typedef logic [ENTRY_WIDTH-1:0]        entry_t;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam cnt_t MAX_COUNT = cnt_t'(MAX_VERTICES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  // true when a and b lie strictly on opposite sides of y
  function automatic logic straddles(coord_t a, coord_t b, coord_t y);
    return ((a < y) && (b > y)) || ((a > y) && (b < y));
  endfunction

endpackage

// ----- hw/rtl/point_in_polygon_crossing.sv -----
// point-in-polygon test by ray crossing over a vertex memory
//
//  channel  ports                                   direction
//  in       in_valid/in_ready, in_cmd, in_x_coord,  in
//           in_y_coord
//  out      out_valid/out_ready, out_inside_res     out
//
// clear and append leave in_ready high and give no result.
// a query inside the box walks the n stored vertices: one read of the vertex
// memory per cycle into a read register, a parity update per vertex, then a
// load of the result register. a query outside the box or on an empty polygon skips the walk.
// rst_n clears the vertex count, the box and all control state; the memory is
// not cleared. in_ready is low while a query walks or its result waits for
// the output register; appends and clears still flow while a result is held.
module point_in_polygon_crossing
  import pipc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_cmd,
  input  coord_t       in_x_coord,
  input  coord_t       in_y_coord,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_inside_res
);

  entry_t vert_mem [MAX_VERTICES];
  entry_t rd_data_r;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  coord_t min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  coord_t min_y_r, min_y_nxt, max_y_r, max_y_nxt;
  coord_t qx_r, qx_nxt, qy_r, qy_nxt;
  coord_t prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  coord_t y0_r, y0_nxt;
  cnt_t   iss_r, iss_nxt;
  logic   dv_r, dv_nxt;
  logic   first_r, first_nxt;
  logic   last_r, last_nxt;
  logic   par_r, par_nxt;
  logic   res_r, res_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_res_r, out_res_nxt;

  logic   in_xfer;
  logic   wr_en;
  logic   rd_en;
  coord_t cur_x, cur_y, close_y;
  logic   edge_hit, close_hit;
  logic   outside;

  assign in_ready       = (state_r == ST_IDLE);
  assign in_xfer        = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_inside_res = out_res_r;

  assign wr_en = in_xfer && (in_cmd == CMD_APPEND) && (cnt_r < MAX_COUNT);
  assign rd_en = (state_r == ST_WALK) && (iss_r < cnt_r);

  // appends and walks never overlap, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vert_mem[cnt_r[ADDR_WIDTH-1:0]] <= {in_x_coord, in_y_coord};
    end
    if (rd_en) begin
      rd_data_r <= vert_mem[iss_r[ADDR_WIDTH-1:0]];
    end
  end

  assign cur_x   = coord_t'(rd_data_r[ENTRY_WIDTH-1:COORD_WIDTH]);
  assign cur_y   = coord_t'(rd_data_r[COORD_WIDTH-1:0]);
  assign close_y = first_r ? cur_y : y0_r;

  // edge from the previous vertex to this one
  assign edge_hit  = !first_r && (prev_x_r > qx_r) && straddles(prev_y_r, cur_y, qy_r);
  // closing edge from the last vertex back to the first
  assign close_hit = last_r && (cur_x > qx_r) && straddles(cur_y, close_y, qy_r);

  assign outside = (cnt_r == '0) || (in_x_coord < min_x_r) || (in_x_coord > max_x_r) ||
                   (in_y_coord < min_y_r) || (in_y_coord > max_y_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    min_x_nxt     = min_x_r;
    max_x_nxt     = max_x_r;
    min_y_nxt     = min_y_r;
    max_y_nxt     = max_y_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    y0_nxt        = y0_r;
    iss_nxt       = iss_r;
    dv_nxt        = rd_en;
    first_nxt     = first_r;
    last_nxt      = last_r;
    par_nxt       = par_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_cmd)
            CMD_CLEAR: begin
              cnt_nxt   = '0;
              min_x_nxt = '0;
              max_x_nxt = '0;
              min_y_nxt = '0;
              max_y_nxt = '0;
            end
            CMD_APPEND: begin
              if (cnt_r < MAX_COUNT) begin
                cnt_nxt = cnt_r + cnt_t'(1);
                if (cnt_r == '0) begin
                  min_x_nxt = in_x_coord;
                  max_x_nxt = in_x_coord;
                  min_y_nxt = in_y_coord;
                  max_y_nxt = in_y_coord;
                end else begin
                  if (in_x_coord < min_x_r) min_x_nxt = in_x_coord;
                  if (in_x_coord > max_x_r) max_x_nxt = in_x_coord;
                  if (in_y_coord < min_y_r) min_y_nxt = in_y_coord;
                  if (in_y_coord > max_y_r) max_y_nxt = in_y_coord;
                end
              end
            end
            CMD_QUERY: begin
              qx_nxt    = in_x_coord;
              qy_nxt    = in_y_coord;
              iss_nxt   = '0;
              first_nxt = 1'b1;
              par_nxt   = 1'b0;
              if (outside) begin
                res_nxt   = 1'b0;
                state_nxt = ST_OUT;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (rd_en) begin
          iss_nxt  = iss_r + cnt_t'(1);
          last_nxt = (iss_r + cnt_t'(1) == cnt_r);
        end
        if (dv_r) begin
          first_nxt  = 1'b0;
          prev_x_nxt = cur_x;
          prev_y_nxt = cur_y;
          if (first_r) y0_nxt = cur_y;
          par_nxt = par_r ^ edge_hit ^ close_hit;
          if (last_r) begin
            res_nxt   = par_r ^ edge_hit ^ close_hit;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      min_x_r     <= '0;
      max_x_r     <= '0;
      min_y_r     <= '0;
      max_y_r     <= '0;
      iss_r       <= '0;
      dv_r        <= 1'b0;
      first_r     <= 1'b0;
      last_r      <= 1'b0;
      par_r       <= 1'b0;
      res_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      min_x_r     <= min_x_nxt;
      max_x_r     <= max_x_nxt;
      min_y_r     <= min_y_nxt;
      max_y_r     <= max_y_nxt;
      iss_r       <= iss_nxt;
      dv_r        <= dv_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      par_r       <= par_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    prev_x_r  <= prev_x_nxt;
    prev_y_r  <= prev_y_nxt;
    y0_r      <= y0_nxt;
    out_res_r <= out_res_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_COUNT)
    else $error("vertex count beyond capacity");

  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (iss_r <= cnt_r))
    else $error("walk read index past vertex count");

  a_data_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> (state_r == ST_WALK))
    else $error("read data returned outside a walk");

  a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_cmd == CMD_QUERY) && (cnt_r == '0)) |=>
      (state_r == ST_OUT) && !res_r)
    else $error("query on empty polygon did not answer zero at once");
`endif

endmodule

// ----- tb/tb_point_in_polygon_crossing.sv -----
`timescale 1ns / 1ps
// testbench for the point-in-polygon crossing block: ray parity predictor and scoreboard
module tb_point_in_polygon_crossing;
  import pipc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET    = 1800;
  localparam int QUIET_FROM     = 1530;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 300;
  localparam coord_t C_MIN = 32'h8000_0000;
  localparam coord_t C_MAX = 32'h7fff_ffff;

  class polygon_scoreboard;
    coord_t vert_x [MAX_VERTICES];
    coord_t vert_y [MAX_VERTICES];
    int unsigned n_vert;
    coord_t min_x, max_x, min_y, max_y;
    bit inside_q [$];
    int unsigned errors, queries, inside_hits, box_rejects, dropped_appends, most_vertices;

    function new();
      n_vert = 0;
      min_x = '0;
      max_x = '0;
      min_y = '0;
      max_y = '0;
      errors = 0;
      queries = 0;
      inside_hits = 0;
      box_rejects = 0;
      dropped_appends = 0;
      most_vertices = 0;
    endfunction

    // parity of the edges whose start vertex lies right of the point and whose end y values strictly straddle it
    function bit ray_parity(coord_t px, coord_t py);
      bit odd;
      int unsigned nxt;
      odd = 1'b0;
      for (int unsigned i = 0; i < n_vert; i++) begin
        nxt = (i + 1 < n_vert) ? i + 1 : 0;
        if (vert_x[i] > px &&
            ((vert_y[i] < py && vert_y[nxt] > py) || (vert_y[i] > py && vert_y[nxt] < py)))
          odd = ~odd;
      end
      return odd;
    endfunction

    function void note_transfer(logic [1:0] cmd, coord_t px, coord_t py);
      bit res;
      case (cmd)
        CMD_CLEAR: begin
          n_vert = 0;
          min_x = '0;
          max_x = '0;
          min_y = '0;
          max_y = '0;
        end
        CMD_APPEND: begin
          if (n_vert >= MAX_VERTICES) begin
            dropped_appends++;
          end else begin
            vert_x[n_vert] = px;
            vert_y[n_vert] = py;
            if (n_vert == 0) begin
              min_x = px;
              max_x = px;
              min_y = py;
              max_y = py;
            end else begin
              if (px < min_x) min_x = px;
              if (px > max_x) max_x = px;
              if (py < min_y) min_y = py;
              if (py > max_y) max_y = py;
            end
            n_vert++;
            if (n_vert > most_vertices) most_vertices = n_vert;
          end
        end
        CMD_QUERY: begin
          if (n_vert == 0 || px < min_x || px > max_x || py < min_y || py > max_y) begin
            res = 1'b0;
            box_rejects++;
          end else begin
            res = ray_parity(px, py);
          end
          inside_q = {inside_q, res};
          queries++;
          if (res) inside_hits++;
        end
        default: ;
      endcase
    endfunction

    function void check_inside(logic got);
      bit want;
      if (inside_q.size() == 0) begin
        errors++;
        $display("%0t: result with no query pending: expected none, actual %b", $time, got);
      end else begin
        want = inside_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: inside_res mismatch: expected %b, actual %b", $time, want, got);
        end
      end
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  logic [1:0] in_cmd;
  coord_t in_x_coord;
  coord_t in_y_coord;
  logic   out_valid;
  logic   out_ready;
  logic   out_inside_res;

  polygon_scoreboard sb;
  int     items_sent;
  int     fills_done;
  bit     quiet;
  coord_t gen_x [$];
  coord_t gen_y [$];

  point_in_polygon_crossing dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_transfer(in_cmd, in_x_coord, in_y_coord);
    if (rst_n && out_valid && out_ready) sb.check_inside(out_inside_res);
  end

  // ends the run when no transfer happens for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // receiver stalls in bursts, none once the run goes quiet
  initial begin
    out_ready <= 1'b0;
    repeat (9) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input coord_t xc, input coord_t yc);
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_x_coord <= xc;
    in_y_coord <= yc;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (cmd != CMD_UNUSED) items_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic coord_t pick_between(longint lo, longint hi);
    longint unsigned r;
    r = {$urandom, $urandom};
    r = r % longint'(hi - lo + 1);
    return coord_t'(lo + longint'(r));
  endfunction

  task automatic build_polygon(input int n, input bit wide, input bit do_clear);
    coord_t cx, cy, xv, yv;
    int span;
    if (do_clear) begin
      send_item(CMD_CLEAR, $urandom, $urandom);
      gen_x.delete();
      gen_y.delete();
    end
    cx = $urandom;
    cy = $urandom;
    span = $urandom_range(1, 4000);
    repeat (n) begin
      xv = wide ? coord_t'($urandom) : cx + coord_t'($urandom_range(0, 2 * span)) - span;
      yv = wide ? coord_t'($urandom) : cy + coord_t'($urandom_range(0, 2 * span)) - span;
      gen_x = {gen_x, xv};
      gen_y = {gen_y, yv};
      send_item(CMD_APPEND, xv, yv);
    end
  endtask

  // mostly points inside the box, some on vertex lines, some anywhere
  task automatic query_points(input int k);
    longint lo_x, hi_x, lo_y, hi_y;
    coord_t qx, qy;
    int sel;
    if (gen_x.size() == 0) begin
      lo_x = C_MIN;
      hi_x = C_MAX;
      lo_y = C_MIN;
      hi_y = C_MAX;
    end else begin
      lo_x = gen_x[0];
      hi_x = gen_x[0];
      lo_y = gen_y[0];
      hi_y = gen_y[0];
      foreach (gen_x[i]) begin
        if (gen_x[i] < lo_x) lo_x = gen_x[i];
        if (gen_x[i] > hi_x) hi_x = gen_x[i];
        if (gen_y[i] < lo_y) lo_y = gen_y[i];
        if (gen_y[i] > hi_y) hi_y = gen_y[i];
      end
    end
    repeat (k) begin
      sel = $urandom_range(0, 9);
      qx = pick_between(lo_x, hi_x);
      qy = pick_between(lo_y, hi_y);
      if (sel == 0) begin
        qx = $urandom;
        qy = $urandom;
      end else if (sel <= 2 && gen_x.size() != 0) begin
        if ($urandom_range(0, 1)) qx = gen_x[$urandom_range(0, gen_x.size() - 1)];
        else qy = gen_y[$urandom_range(0, gen_y.size() - 1)];
      end
      send_item(CMD_QUERY, qx, qy);
    end
  endtask

  task automatic fill_store();
    int extras;
    build_polygon(MAX_VERTICES, fills_done == 0, 1'b1);
    extras = $urandom_range(1, 4);
    repeat (extras) send_item(CMD_APPEND, $urandom, $urandom);
    items_sent -= extras;
    query_points(4);
    fills_done++;
  endtask

  task automatic run_directed();
    send_item(CMD_QUERY, 0, 0);
    send_item(CMD_QUERY, C_MIN, C_MAX);
    send_item(CMD_UNUSED, C_MAX, C_MIN);
    send_item(CMD_APPEND, C_MIN, C_MIN);
    send_item(CMD_APPEND, C_MAX, C_MIN);
    send_item(CMD_APPEND, C_MAX, C_MAX);
    send_item(CMD_APPEND, C_MIN, C_MAX);
    send_item(CMD_QUERY, 0, 0);
    send_item(CMD_QUERY, C_MAX, 0);
    send_item(CMD_QUERY, C_MIN, C_MIN);
    send_item(CMD_QUERY, C_MIN, -1);
    send_item(CMD_UNUSED, '1, '1);
    send_item(CMD_CLEAR, '1, '1);
    send_item(CMD_QUERY, 0, 0);
    // box must start from the first vertex, not from zero
    send_item(CMD_APPEND, -100, -100);
    send_item(CMD_QUERY, -100, -100);
    send_item(CMD_APPEND, -50, -100);
    send_item(CMD_APPEND, -50, -50);
    send_item(CMD_QUERY, -60, -80);
    send_item(CMD_QUERY, -101, -80);
    send_item(CMD_QUERY, -49, -80);
    send_item(CMD_QUERY, -60, -101);
    send_item(CMD_QUERY, -60, -49);
    send_item(CMD_QUERY, -50, -75);
  endtask

  task automatic run_random();
    int sel;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
      if (fills_done < 2 && items_sent >= 500 + 600 * fills_done) fill_store();
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        build_polygon((sel < 70) ? $urandom_range(3, 12) : $urandom_range(1, 40),
                      $urandom_range(0, 3) == 0, 1'b1);
        query_points($urandom_range(1, 8));
      end else if (sel < 90) begin
        // noise: any command, any payload
        repeat ($urandom_range(1, 4)) send_item(2'($urandom_range(0, 3)), $urandom, $urandom);
      end else begin
        build_polygon($urandom_range(1, 4), $urandom_range(0, 1), 1'b0);
        query_points($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    fills_done = 0;
    quiet = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_cmd     <= CMD_CLEAR;
    in_x_coord <= '0;
    in_y_coord <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.inside_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d queries (%0d inside, %0d empty or outside the box),",
             sb.queries, sb.inside_hits, sb.box_rejects);
    $display("%0d full-store drops; largest polygon held %0d vertices; %0d mismatches",
             sb.dropped_appends, sb.most_vertices, sb.errors);
    if (sb.errors == 0 && sb.inside_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/pipc_pkg.sv
hw/rtl/point_in_polygon_crossing.sv
tb/tb_point_in_polygon_crossing.sv
